// ----- hdl/dtmfep_pkg.sv -----
// ----------------------------------------------------------------------------
// dtmfep_pkg
// Shared types, constants and the tone code decoder for the telephone-event
// packet sender.
// ----------------------------------------------------------------------------
package dtmfep_pkg;

	localparam int STOP_PACKETS = 3;
	localparam int CNT_W        = 4;
	localparam int DUR_W        = 16;
	localparam int TS_W         = 32;

	localparam logic [5:0]       VOLUME_DBM = 6'd10;
	localparam logic [DUR_W-1:0] DUR_MAX    = {DUR_W{1'b1}};

	// stop countdown codes (signed)
	localparam logic signed [CNT_W-1:0] CNT_IDLE = -4'sd1;
	localparam logic signed [CNT_W-1:0] CNT_ONE  = 4'sd1;
	localparam logic signed [CNT_W-1:0] CNT_STOP = CNT_W'(STOP_PACKETS);

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_EVENTS_ENABLED = 2'd0,
		REG_PAYLOAD_TYPE   = 2'd1,
		REG_TS_STEP        = 2'd2,
		REG_FRAME_SAMPLES  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] tone_code;
	} req_t;

	typedef struct packed {
		logic [6:0]       payload_type;
		logic             marker;
		logic [4:0]       event_number;
		logic             end_flag;
		logic [5:0]       volume;
		logic [DUR_W-1:0] duration;
		logic [TS_W-1:0]  event_timestamp;
	} pkt_t;

	typedef struct packed {
		logic        events_enabled;
		logic [6:0]  event_payload_type;
		logic [15:0] timestamp_step;
		logic [15:0] frame_samples;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] number;
	} tone_map_t;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UD    = 8'h44;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] NUM_MAX  = 8'd16;
	localparam logic [7:0] EV_LETTER = 8'd12;
	localparam logic [4:0] EV_STAR  = 5'd10;
	localparam logic [4:0] EV_HASH  = 5'd11;

	// map a character or raw number to a telephone event number
	function automatic tone_map_t map_tone(input logic [7:0] c);
		tone_map_t r;
		logic [7:0] t;
		r = '0;
		t = '0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
			r = '{valid: 1'b1, number: t[4:0]};
		end else if (c <= NUM_MAX) begin
			r = '{valid: 1'b1, number: c[4:0]};
		end else if (c >= CH_UA && c <= CH_UD) begin
			t = c - CH_UA + EV_LETTER;
			r = '{valid: 1'b1, number: t[4:0]};
		end else if (c >= CH_LA && c <= CH_LD) begin
			t = c - CH_LA + EV_LETTER;
			r = '{valid: 1'b1, number: t[4:0]};
		end else if (c == CH_STAR) begin
			r = '{valid: 1'b1, number: EV_STAR};
		end else if (c == CH_HASH) begin
			r = '{valid: 1'b1, number: EV_HASH};
		end
		return r;
	endfunction

endpackage

// ----- hdl/dtmfep_cfg.sv -----
// ----------------------------------------------------------------------------
// dtmfep_cfg
// Configuration register bank, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module dtmfep_cfg import dtmfep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.events_enabled     <= 1'b0;
			cfg_q.event_payload_type <= 7'd101;
			cfg_q.timestamp_step     <= 16'd80;
			cfg_q.frame_samples      <= 16'd80;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EVENTS_ENABLED: cfg_q.events_enabled     <= cfg_data[0];
				REG_PAYLOAD_TYPE:   cfg_q.event_payload_type <= cfg_data[6:0];
				REG_TS_STEP:        cfg_q.timestamp_step     <= cfg_data;
				REG_FRAME_SAMPLES:  cfg_q.frame_samples      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/dtmfep_engine.sv -----
// ----------------------------------------------------------------------------
// dtmfep_engine
// Tone state and packet decision for one item per cycle while step_en is high.
// ----------------------------------------------------------------------------
module dtmfep_engine import dtmfep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step_en,
	input  req_t req,
	output logic emit,
	output pkt_t pkt
);

	logic [TS_W-1:0]         fts_q, fts_d;
	logic                    active_q, active_d;
	logic [4:0]              event_q, event_d;
	logic                    first_q, first_d;
	logic signed [CNT_W-1:0] cnt_q, cnt_d;
	logic [TS_W-1:0]         start_q, start_d;
	logic [TS_W-1:0]         last_q, last_d;
	logic [DUR_W-1:0]        final_q, final_d;

	logic [TS_W-1:0]         ts;
	logic [TS_W-1:0]         start_eff;
	logic signed [CNT_W-1:0] cnt_eff;
	logic signed [CNT_W-1:0] cnt_dec;
	logic [TS_W-1:0]         due;
	logic [TS_W-1:0]         span_stop;
	logic [TS_W-1:0]         span_run;
	logic [DUR_W-1:0]        dur_stop;
	logic [DUR_W-1:0]        dur_run;
	logic [DUR_W-1:0]        final_eff;
	tone_map_t               tm;

	assign ts        = fts_q + TS_W'(cfg.timestamp_step);
	assign start_eff = first_q ? ts : start_q;
	assign cnt_eff   = first_q ? CNT_IDLE : cnt_q;
	assign cnt_dec   = cnt_eff - CNT_ONE;
	assign due       = last_q + {15'd0, cfg.frame_samples, 1'b0};
	assign span_stop = ts - start_eff;
	assign span_run  = ts + TS_W'(cfg.frame_samples) - start_eff;
	assign dur_stop  = (span_stop[TS_W-1:DUR_W] != '0) ? DUR_MAX : span_stop[DUR_W-1:0];
	assign dur_run   = (span_run[TS_W-1:DUR_W] != '0) ? DUR_MAX : span_run[DUR_W-1:0];
	assign final_eff = (cnt_eff == CNT_STOP) ? dur_stop : final_q;
	assign tm        = map_tone(req.tone_code);

	always_comb begin
		fts_d    = fts_q;
		active_d = active_q;
		event_d  = event_q;
		first_d  = first_q;
		cnt_d    = cnt_q;
		start_d  = start_q;
		last_d   = last_q;
		final_d  = final_q;
		emit     = 1'b0;
		pkt      = '{payload_type: cfg.event_payload_type, marker: 1'b0,
			event_number: event_q, end_flag: 1'b0, volume: VOLUME_DBM,
			duration: dur_run, event_timestamp: start_eff};
		case (mode_t'(req.mode))
			MODE_START: begin
				if (cfg.events_enabled && !active_q && (cnt_q < CNT_ONE) && tm.valid) begin
					active_d = 1'b1;
					event_d  = tm.number;
					first_d  = 1'b1;
				end
			end
			MODE_STOP: begin
				if (active_q && (cnt_q < CNT_ONE))
					cnt_d = CNT_STOP;
			end
			MODE_TICK: begin
				fts_d = ts;
				if (cfg.events_enabled && active_q) begin
					start_d = start_eff;
					cnt_d   = cnt_eff;
					final_d = final_eff;
					if (cnt_eff < 0) begin
						if (first_q || due <= ts) begin
							emit       = 1'b1;
							pkt.marker = first_q;
							last_d     = ts;
							first_d    = 1'b0;
						end
					end else begin
						// end packet with the frozen duration
						emit         = 1'b1;
						pkt.end_flag = 1'b1;
						pkt.duration = final_eff;
						last_d       = ts;
						if (cnt_dec < CNT_ONE) begin
							active_d = 1'b0;
							cnt_d    = CNT_IDLE;
							final_d  = '0;
						end else begin
							cnt_d = cnt_dec;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fts_q    <= '0;
			active_q <= 1'b0;
			event_q  <= '0;
			first_q  <= 1'b0;
			cnt_q    <= CNT_IDLE;
			final_q  <= '0;
		end else if (step_en) begin
			fts_q    <= fts_d;
			active_q <= active_d;
			event_q  <= event_d;
			first_q  <= first_d;
			cnt_q    <= cnt_d;
			final_q  <= final_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			start_q <= start_d;
			last_q  <= last_d;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_IDLE || (cnt_q >= CNT_ONE && cnt_q <= CNT_STOP))
		else $error("stop countdown out of range");

	a_cnt_needs_tone: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != CNT_IDLE |-> active_q)
		else $error("stop countdown running without an active tone");

	a_first_needs_tone: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> active_q)
		else $error("first packet pending without an active tone");

	a_last_end_drops: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && emit && pkt.end_flag && cnt_q == CNT_ONE |=> !active_q)
		else $error("tone still active after its last end packet");

endmodule

// ----- hdl/dtmf_event_packet_sender_core.sv -----
// ----------------------------------------------------------------------------
// dtmf_event_packet_sender_core
// Telephone-event (DTMF) packet sender: turns tone start, stop and frame tick
// items into event packet descriptors.
// ----------------------------------------------------------------------------
// Each item on req is a frame tick, a tone start or a tone stop. Ticks advance
// a 32-bit frame timestamp by timestamp_step; while a tone is active a tick
// sends an event packet on the first tick of the tone and then whenever twice
// frame_samples has passed since the last one. A stop makes the next three
// ticks send end packets with the E bit and a frozen duration. Starts and
// stops never produce a packet. The block takes one item per clock: an item
// is captured in an input stage, decided by the engine as the stage advances
// and its packet, if any, is loaded into the output register that drives pkt.
// The output register is the only thing that can hold the input stage back,
// so throughput stays at one item per cycle while pkt_ready is high. Write
// configuration only with no items in flight.
// ----------------------------------------------------------------------------
module dtmf_event_packet_sender_core import dtmfep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        pkt_valid,
	input  logic        pkt_ready,
	output pkt_t        pkt,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	logic adv;
	logic emit;
	pkt_t pkt_d;
	pkt_t pkt_q;
	logic pkt_valid_q;

	// advance the input stage whenever the output register can take its result
	assign adv       = valid_s1 && (!pkt_valid_q || pkt_ready);
	assign req_ready = !valid_s1 || adv;
	assign pkt_valid = pkt_valid_q;
	assign pkt       = pkt_q;

	dtmfep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dtmfep_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (adv),
		.req     (req_s1),
		.emit    (emit),
		.pkt     (pkt_d)
	);

	// input stage: hold the item until the engine takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	// output register: load a new packet, or drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
		end else if (adv) begin
			pkt_valid_q <= emit;
		end else if (pkt_ready) begin
			pkt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			pkt_q <= pkt_d;
	end

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("input stage lost or changed a waiting item");

endmodule
